[design/u8sv_pkg.sv]
// Shared types and constants for the UTF-8 stream validator.
// Depends on nothing; imported by u8sv_core and utf8_stream_validator.
package u8sv_pkg;

    // Default width of the byte offset counters
    localparam int OFFSET_BITS_DEF = 32;
    // Width of the reported offset field
    localparam int OUT_BITS        = 32;

    // One byte of the stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    // Verdict for one stream
    typedef struct packed {
        logic                stream_ok;
        logic [OUT_BITS-1:0] bad_offset;
    } verdict_t;

endpackage

[design/utf8_stream_validator.sv]
// Strict UTF-8 stream validator, top level.
// Byte channel in, verdict channel out, both valid/stall.
// Each stream is a run of bytes, the final one marked by last_byte.
// Every byte is checked for NUL, stray continuation bytes, bad leads,
// truncation, overlong forms, values above U+10FFFF and surrogates.
// One verdict leaves per stream, on its last byte: stream_ok and the
// 1-based offset of the first bad byte (0 when the stream is good).
// Throughput: one byte per cycle while byte_stall is low, set by the
// combinational check between the request and verdict registers.
// The verdict is computed while the last byte sits in the request register
// and is then registered in the verdict register.
// A byte that causes no verdict is never stalled in the request register,
// regardless of the verdict side.
// Receiver stall: the verdict is held; bytes keep flowing until a new last
// byte reaches the check with the verdict register still full, and then
// byte_stall rises.
// Reset clears all stream state and both valid flags at once.
// Depends on u8sv_pkg and u8sv_core.
module utf8_stream_validator
    import u8sv_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  byte_req_t byte_req,
    output logic      verdict_valid,
    input  logic      verdict_stall,
    output verdict_t  verdict
);

    logic      req_valid_reg;
    byte_req_t req_reg;
    logic      out_valid_reg;
    verdict_t  out_reg;
    logic      out_free;
    logic      step;
    verdict_t  verdict_comb;

    // Advance the held request unless it needs a full verdict register
    assign out_free   = !out_valid_reg || !verdict_stall;
    assign step       = req_valid_reg && (!req_reg.last_byte || out_free);
    assign byte_stall = req_valid_reg && !step;

    u8sv_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .req     (req_reg),
        .verdict (verdict_comb)
    );

    // Hold the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            req_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            req_reg <= byte_req;
        end
    end

    // Hold the verdict until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && req_reg.last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && req_reg.last_byte)
        begin
            out_reg <= verdict_comb;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_reg;

endmodule

[design/u8sv_core.sv]
// Per-byte UTF-8 checking logic and stream state registers.
// Depends on u8sv_pkg for the request and verdict types.
module u8sv_core
    import u8sv_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  byte_req_t req,
    output verdict_t  verdict
);

    localparam logic [20:0] CP_MIN_2  = 21'h00080;
    localparam logic [20:0] CP_MAX_2  = 21'h007FF;
    localparam logic [20:0] CP_MIN_3  = 21'h00800;
    localparam logic [20:0] CP_MAX_3  = 21'h0FFFF;
    localparam logic [20:0] CP_MIN_4  = 21'h10000;
    localparam logic [20:0] CP_MAX_4  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h0D800;
    localparam logic [20:0] SURR_HI   = 21'h0DFFF;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    logic [OFFSET_BITS-1:0] byte_position_reg, byte_position_next;
    logic [1:0]             bytes_remaining_reg, bytes_remaining_next;
    logic [1:0]             sequence_length_reg, sequence_length_next;
    logic [20:0]            code_point_reg, code_point_next;
    logic [OFFSET_BITS-1:0] lead_position_reg, lead_position_next;
    logic [OFFSET_BITS-1:0] pending_bad_reg, pending_bad_next;
    logic [OFFSET_BITS-1:0] first_error_reg, first_error_next;

    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] err;
    logic [1:0]             need;
    logic [20:0]            lead_bits;
    logic [20:0]            cp_shift;
    logic                   value_good;
    logic [7:0]             b;

    assign b = req.data_byte;

    // Advance the saturating byte position
    assign pos = (&byte_position_reg) ? byte_position_reg
                                      : byte_position_reg + 1'b1;

    // Append the payload bits of a continuation byte
    assign cp_shift = {code_point_reg[14:0], b[5:0]};

    // Decode a lead byte into continuation count and payload bits
    always_comb
    begin
        need      = NEED_NONE;
        lead_bits = '0;
        if (b[7:5] == 3'b110)
        begin
            need      = NEED_ONE;
            lead_bits = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            need      = NEED_TWO;
            lead_bits = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            need      = NEED_THREE;
            lead_bits = {18'd0, b[2:0]};
        end
    end

    // Check the assembled value for range, overlong form and surrogates
    always_comb
    begin
        unique case (sequence_length_reg)
            NEED_ONE:   value_good = (cp_shift >= CP_MIN_2) &&
                                     (cp_shift <= CP_MAX_2);
            NEED_TWO:   value_good = (cp_shift >= CP_MIN_3) &&
                                     (cp_shift <= CP_MAX_3);
            default:    value_good = (cp_shift >= CP_MIN_4) &&
                                     (cp_shift <= CP_MAX_4);
        endcase
        if ((cp_shift >= SURR_LO) && (cp_shift <= SURR_HI))
        begin
            value_good = 1'b0;
        end
    end

    // Step the stream state for one byte
    always_comb
    begin
        byte_position_next   = pos;
        bytes_remaining_next = bytes_remaining_reg;
        sequence_length_next = sequence_length_reg;
        code_point_next      = code_point_reg;
        lead_position_next   = lead_position_reg;
        pending_bad_next     = pending_bad_reg;
        first_error_next     = first_error_reg;

        if (first_error_reg != '0)
        begin
            // error already decided; drop the byte
        end
        else if (bytes_remaining_reg != NEED_NONE)
        begin
            if (pending_bad_reg == '0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    pending_bad_next = pos;
                end
                else
                begin
                    code_point_next = cp_shift;
                end
            end
            bytes_remaining_next = bytes_remaining_reg - 2'd1;
            if (bytes_remaining_next == NEED_NONE)
            begin
                if (pending_bad_next != '0)
                begin
                    first_error_next = pending_bad_next;
                end
                else if (!value_good)
                begin
                    first_error_next = lead_position_reg;
                end
                pending_bad_next = '0;
            end
        end
        else if (b == 8'h00)
        begin
            first_error_next = pos;
        end
        else if (b[7] == 1'b0)
        begin
            // plain ASCII
        end
        else if (need == NEED_NONE)
        begin
            first_error_next = pos;
        end
        else
        begin
            bytes_remaining_next = need;
            sequence_length_next = need;
            code_point_next      = lead_bits;
            lead_position_next   = pos;
            pending_bad_next     = '0;
        end
    end

    // Pick the first error, falling back to the lead of a truncated sequence
    assign err = ((first_error_next == '0) && (bytes_remaining_next != NEED_NONE))
                 ? lead_position_next : first_error_next;

    // Saturate or zero-extend the offset into the reported field
    generate
        if (OFFSET_BITS > OUT_BITS)
        begin : g_sat
            assign verdict.bad_offset = (|err[OFFSET_BITS-1:OUT_BITS])
                                        ? {OUT_BITS{1'b1}} : err[OUT_BITS-1:0];
        end
        else if (OFFSET_BITS == OUT_BITS)
        begin : g_same
            assign verdict.bad_offset = err;
        end
        else
        begin : g_ext
            assign verdict.bad_offset = {{(OUT_BITS-OFFSET_BITS){1'b0}}, err};
        end
    endgenerate

    assign verdict.stream_ok = (err == '0);

    // Hold state; clear it after the last byte of a stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            bytes_remaining_reg <= '0;
            sequence_length_reg <= '0;
            code_point_reg      <= '0;
            lead_position_reg   <= '0;
            pending_bad_reg     <= '0;
            first_error_reg     <= '0;
        end
        else if (step)
        begin
            if (req.last_byte)
            begin
                byte_position_reg   <= '0;
                bytes_remaining_reg <= '0;
                sequence_length_reg <= '0;
                code_point_reg      <= '0;
                lead_position_reg   <= '0;
                pending_bad_reg     <= '0;
                first_error_reg     <= '0;
            end
            else
            begin
                byte_position_reg   <= byte_position_next;
                bytes_remaining_reg <= bytes_remaining_next;
                sequence_length_reg <= sequence_length_next;
                code_point_reg      <= code_point_next;
                lead_position_reg   <= lead_position_next;
                pending_bad_reg     <= pending_bad_next;
                first_error_reg     <= first_error_next;
            end
        end
    end

endmodule
